>>> design/urm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_pkg: shared types and constants for the ultrasonic range meter
// Register map, controller states, divider sizing and command/status bundles.
// ----------------------------------------------------------------------------
package urm_pkg;

  // register map
  localparam int unsigned NumRegs    = 2;
  localparam int unsigned AddrW      = 3;
  localparam int unsigned RegIdxW    = 1;

  typedef enum logic [RegIdxW-1:0] {
    REG_UPDATE_TICKS = 1'b0,
    REG_TICKS_PER_US = 1'b1
  } urm_reg_e;

  // field widths
  localparam int unsigned TicksW     = 16;
  localparam int unsigned RateW      = 8;
  localparam int unsigned CountW     = 32;
  localparam int unsigned DigitW     = 4;
  localparam int unsigned NumDigits  = 4;
  localparam int unsigned DigitCntW  = $clog2(NumDigits);

  // reset values
  localparam logic [TicksW-1:0] UpdateTicksRst = 16'd100;
  localparam logic [RateW-1:0]  TicksPerUsRst  = 8'd25;

  // divider constants
  localparam int unsigned      DivSteps    = CountW;
  localparam int unsigned      DivCntW     = $clog2(DivSteps);

  // reciprocals: width/58 as (width/2)*ceil(2^36/29) >> 36, x/10 as x*ceil(2^35/10) >> 35
  localparam logic [CountW-1:0] RecipCm  = 32'd2369637129;
  localparam logic [CountW-1:0] RecipTen = 32'hCCCC_CCCD;
  localparam int unsigned       CmShift  = 36;
  localparam int unsigned       TenShift = 35;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EDGE_DIV,
    ST_EDGE_WR,
    ST_CM_DIV,
    ST_DEC_LOAD,
    ST_DEC_DIV,
    ST_DEC_SAVE,
    ST_FINISH
  } urm_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic tick;
    logic load_edge;
    logic load_cm;
    logic load_dec;
    logic dec_split;
    logic step;
    logic width_wr;
    logic digit_shift;
    logic width_clr;
    logic out_load;
    logic out_upd;
  } urm_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic hit;
  } urm_stat_t;

endpackage

>>> design/urm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_ctrl: request sequencer
// Runs each request through divider or multiplier as needed, loads the result.
// ----------------------------------------------------------------------------
module urm_ctrl import urm_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      mode_i,
  input  logic      echo_level_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  urm_stat_t stat_i,
  output urm_cmd_t  cmd_o
);

  urm_state_e           state_q, state_d;
  logic [DivCntW-1:0]   step_q, step_d;
  logic [DigitCntW-1:0] dig_q, dig_d;
  logic                 upd_q, upd_d;
  logic                 out_valid_q, out_valid_d;
  logic                 step_last;

  assign step_last   = (step_q == DivCntW'(DivSteps - 1));
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;

  // state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      dig_q       <= '0;
      upd_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      dig_q       <= dig_d;
      upd_q       <= upd_d;
      out_valid_q <= out_valid_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    dig_d       = dig_q;
    upd_d       = upd_q;
    out_valid_d = out_valid_q;
    cmd_o       = '0;

    // result taken downstream
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        step_d = '0;
        dig_d  = '0;
        if (in_valid_i) begin
          if (!mode_i) begin
            cmd_o.tick = 1'b1;
            upd_d      = stat_i.hit;
            if (stat_i.hit) begin
              state_d = ST_CM_DIV;
            end else begin
              state_d = ST_FINISH;
            end
          end else if (!echo_level_i) begin
            upd_d           = 1'b0;
            cmd_o.load_edge = 1'b1;
            state_d         = ST_EDGE_DIV;
          end else begin
            upd_d   = 1'b0;
            state_d = ST_FINISH;
          end
        end
      end
      ST_EDGE_DIV: begin
        cmd_o.step = 1'b1;
        step_d     = step_q + 1'b1;
        if (step_last) begin
          state_d = ST_EDGE_WR;
        end
      end
      ST_EDGE_WR: begin
        cmd_o.width_wr = 1'b1;
        state_d        = ST_FINISH;
      end
      // width to centimetres in one multiply
      ST_CM_DIV: begin
        cmd_o.load_cm = 1'b1;
        state_d       = ST_DEC_LOAD;
      end
      ST_DEC_LOAD: begin
        cmd_o.load_dec = 1'b1;
        state_d        = ST_DEC_DIV;
      end
      ST_DEC_DIV: begin
        cmd_o.dec_split = 1'b1;
        state_d         = ST_DEC_SAVE;
      end
      ST_DEC_SAVE: begin
        cmd_o.digit_shift = 1'b1;
        dig_d             = dig_q + 1'b1;
        if (dig_q == DigitCntW'(NumDigits - 1)) begin
          cmd_o.width_clr = 1'b1;
          state_d         = ST_FINISH;
        end else begin
          state_d = ST_DEC_LOAD;
        end
      end
      ST_FINISH: begin
        // wait for the result register to be free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_upd  = upd_q;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> design/urm_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// urm_dpath: range meter datapath
// Tick countdown, pulse width, digits, radix-2 divider for the echo width,
// reciprocal multiplier for the centimetre and decimal steps, result register.
// ----------------------------------------------------------------------------
module urm_dpath import urm_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  urm_cmd_t              cmd_i,
  output urm_stat_t             stat_o,
  input  logic [TicksW-1:0]     update_ticks_i,
  input  logic [RateW-1:0]      ticks_per_us_i,
  input  logic [CountW-1:0]     capture_count_i,
  output logic                  backplane_o,
  output logic                  trigger_start_o,
  output logic                  update_done_o,
  output logic [DigitW-1:0]     digit_ones_o,
  output logic [DigitW-1:0]     digit_tens_o,
  output logic [DigitW-1:0]     digit_hundreds_o,
  output logic [DigitW-1:0]     digit_thousands_o,
  output logic [CountW-1:0]     echo_width_us_o
);

  logic [TicksW-1:0]   cd_q, cd_d, cd_dec;
  logic [CountW-1:0]   width_q, width_d;
  logic                bp_q, bp_d;
  logic [DigitW-1:0]   dig_q [NumDigits];
  logic [CountW-1:0]   dvd_q, dvd_d;
  logic [RateW-1:0]    rem_q, rem_d;
  logic [RateW-1:0]    dvs_q, dvs_d;
  logic [RateW:0]      rem_sh, rem_diff;
  logic                rem_ge;
  logic [CountW-1:0]   quo_q, quo_d;
  logic [CountW-1:0]   mul_a, mul_b;
  logic [2*CountW-1:0] mul_p;
  logic [CountW-1:0]   cm_quo, ten_quo, ten_rem;

  // countdown compare
  assign cd_dec     = cd_q - 1'b1;
  assign stat_o.hit = (cd_dec == '0);

  // architectural state
  always_comb begin
    cd_d    = cd_q;
    bp_d    = bp_q;
    width_d = width_q;
    if (cmd_i.tick) begin
      cd_d = stat_o.hit ? update_ticks_i : cd_dec;
      bp_d = ~bp_q;
    end
    if (cmd_i.width_wr) begin
      width_d = dvd_q;
    end
    if (cmd_i.width_clr) begin
      width_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cd_q    <= UpdateTicksRst;
      bp_q    <= 1'b0;
      width_q <= '0;
    end else begin
      cd_q    <= cd_d;
      bp_q    <= bp_d;
      width_q <= width_d;
    end
  end

  // digit shift register, ones digit comes out first
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumDigits; i++) begin
        dig_q[i] <= '0;
      end
    end else if (cmd_i.digit_shift) begin
      for (int i = 0; i < NumDigits - 1; i++) begin
        dig_q[i] <= dig_q[i+1];
      end
      dig_q[NumDigits-1] <= rem_q[DigitW-1:0];
    end
  end

  // restoring divider step, quotient shifts into the dividend register
  assign rem_sh   = {rem_q, dvd_q[CountW-1]};
  assign rem_ge   = (rem_sh >= {1'b0, dvs_q});
  assign rem_diff = rem_sh - {1'b0, dvs_q};

  // shared reciprocal multiplier, halved width for cm, running value for digits
  assign mul_a   = cmd_i.load_cm ? {1'b0, width_q[CountW-1:1]} : dvd_q;
  assign mul_b   = cmd_i.load_cm ? RecipCm : RecipTen;
  assign mul_p   = mul_a * mul_b;
  assign cm_quo  = {{(CmShift-CountW){1'b0}}, mul_p[2*CountW-1:CmShift]};
  assign ten_quo = {{(TenShift-CountW){1'b0}}, mul_p[2*CountW-1:TenShift]};
  assign ten_rem = dvd_q - {quo_q[CountW-4:0], 3'b000} - {quo_q[CountW-2:0], 1'b0};

  always_comb begin
    dvd_d = dvd_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    quo_d = quo_q;
    if (cmd_i.load_edge) begin
      dvd_d = capture_count_i;
      dvs_d = ticks_per_us_i;
      rem_d = '0;
    end else if (cmd_i.load_cm) begin
      dvd_d = cm_quo;
    end else if (cmd_i.load_dec) begin
      quo_d = ten_quo;
    end else if (cmd_i.dec_split) begin
      dvd_d = quo_q;
      rem_d = ten_rem[RateW-1:0];
    end else if (cmd_i.step) begin
      dvd_d = {dvd_q[CountW-2:0], rem_ge};
      rem_d = rem_ge ? rem_diff[RateW-1:0] : rem_sh[RateW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    quo_q <= quo_d;
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      backplane_o       <= bp_q;
      trigger_start_o   <= cmd_i.out_upd;
      update_done_o     <= cmd_i.out_upd;
      digit_ones_o      <= dig_q[0];
      digit_tens_o      <= dig_q[1];
      digit_hundreds_o  <= dig_q[2];
      digit_thousands_o <= dig_q[3];
      echo_width_us_o   <= width_q;
    end
  end

endmodule

>>> design/ultrasonic_range_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_meter: echo width capture and four-digit cm readout
// Steps: a falling edge runs the bit-serial width divider; a tick that
// refreshes the digits runs one cm multiply, then load, split, save per digit.
// Throughput: one request at a time; the next waits until the last is loaded.
// Reset: asynchronous active low; registers return to 100 and 25, state clears.
// ----------------------------------------------------------------------------
module ultrasonic_range_meter import urm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  // apb configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // request channel
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              mode_i,
  input  logic              echo_level_i,
  input  logic [CountW-1:0] capture_count_i,
  // result channel
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              backplane_o,
  output logic              trigger_start_o,
  output logic              update_done_o,
  output logic [DigitW-1:0] digit_ones_o,
  output logic [DigitW-1:0] digit_tens_o,
  output logic [DigitW-1:0] digit_hundreds_o,
  output logic [DigitW-1:0] digit_thousands_o,
  output logic [CountW-1:0] echo_width_us_o
);

  logic [TicksW-1:0] update_ticks_q;
  logic [RateW-1:0]  ticks_per_us_q;
  urm_reg_e          reg_idx;
  logic              reg_wr;
  urm_cmd_t          cmd;
  urm_stat_t         stat;

  // configuration registers
  assign pready  = 1'b1;
  assign reg_idx = urm_reg_e'(paddr[AddrW-1 -: RegIdxW]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      update_ticks_q <= UpdateTicksRst;
      ticks_per_us_q <= TicksPerUsRst;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_UPDATE_TICKS: update_ticks_q <= pwdata[TicksW-1:0];
        REG_TICKS_PER_US: ticks_per_us_q <= pwdata[RateW-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_idx)
      REG_UPDATE_TICKS: prdata = {{(32-TicksW){1'b0}}, update_ticks_q};
      REG_TICKS_PER_US: prdata = {{(32-RateW){1'b0}}, ticks_per_us_q};
      default:          prdata = '0;
    endcase
  end

  // sequencer
  urm_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .mode_i       (mode_i),
    .echo_level_i (echo_level_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  // datapath
  urm_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .stat_o            (stat),
    .update_ticks_i    (update_ticks_q),
    .ticks_per_us_i    (ticks_per_us_q),
    .capture_count_i   (capture_count_i),
    .backplane_o       (backplane_o),
    .trigger_start_o   (trigger_start_o),
    .update_done_o     (update_done_o),
    .digit_ones_o      (digit_ones_o),
    .digit_tens_o      (digit_tens_o),
    .digit_hundreds_o  (digit_hundreds_o),
    .digit_thousands_o (digit_thousands_o),
    .echo_width_us_o   (echo_width_us_o)
  );

endmodule

>>> test/ultrasonic_range_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_range_meter_tb: self-checking bench for the echo range meter
// Sends display ticks and echo edges over valid/ready, keeps a local model of
// the countdown, pulse width, backplane and digits, and checks every readout
// field in order. Registers are set over apb between drained phases, from
// the extremes to random values, with random stalls on both sides.
// ----------------------------------------------------------------------------
module ultrasonic_range_meter_tb;
  import urm_pkg::*;

  localparam logic MODE_TICK  = 1'b0;
  localparam logic MODE_EDGE  = 1'b1;
  localparam logic LEVEL_FALL = 1'b0;
  localparam logic LEVEL_RISE = 1'b1;
  localparam int unsigned US_PER_CM     = 58;
  localparam int unsigned RADIX         = 10;
  localparam int unsigned LONG_HOLD     = 400;
  localparam int unsigned RANDOM_ROUNDS = 6;
  localparam int unsigned ROUND_ITEMS   = 200;
  localparam int unsigned MAX_LOGGED    = 30;

  typedef struct packed {
    logic              mode;
    logic              level;
    logic [CountW-1:0] count;
  } echo_req_t;

  typedef struct packed {
    logic                             backplane;
    logic                             trigger;
    logic                             done;
    logic [NumDigits-1:0][DigitW-1:0] digits;
    logic [CountW-1:0]                width;
  } readout_t;

  // clock, reset and block ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              mode_i = MODE_TICK;
  logic              echo_level_i = LEVEL_FALL;
  logic [CountW-1:0] capture_count_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic              backplane_o;
  logic              trigger_start_o;
  logic              update_done_o;
  logic [DigitW-1:0] digit_ones_o;
  logic [DigitW-1:0] digit_tens_o;
  logic [DigitW-1:0] digit_hundreds_o;
  logic [DigitW-1:0] digit_thousands_o;
  logic [CountW-1:0] echo_width_us_o;

  // pending requests and expected readouts
  echo_req_t request_q[$];
  readout_t  readout_q[$];
  echo_req_t pend;

  // local model of the meter
  logic [TicksW-1:0]                upd_ticks_q = UpdateTicksRst;
  logic [RateW-1:0]                 rate_q = TicksPerUsRst;
  logic [TicksW-1:0]                countdown_q = UpdateTicksRst;
  logic [CountW-1:0]                width_q = '0;
  logic                             backplane_q = 1'b0;
  logic [NumDigits-1:0][DigitW-1:0] digits_q = '0;

  // run control and tallies
  logic        idle_bursts_on = 1'b0;
  int unsigned offer_gap = 0;
  int unsigned accept_hold = 0;
  int unsigned hold_asks = 0;
  int unsigned hold_served = 0;
  int unsigned requests_sent = 0;
  int unsigned readouts_seen = 0;
  int unsigned refreshes_seen = 0;
  int unsigned errors = 0;

  ultrasonic_range_meter dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .mode_i            (mode_i),
    .echo_level_i      (echo_level_i),
    .capture_count_i   (capture_count_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .backplane_o       (backplane_o),
    .trigger_start_o   (trigger_start_o),
    .update_done_o     (update_done_o),
    .digit_ones_o      (digit_ones_o),
    .digit_tens_o      (digit_tens_o),
    .digit_hundreds_o  (digit_hundreds_o),
    .digit_thousands_o (digit_thousands_o),
    .echo_width_us_o   (echo_width_us_o)
  );

  // 50 MHz clock
  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  task automatic report_mismatch(string msg);
    errors++;
    if (errors <= MAX_LOGGED) $display("%0t ns mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, longint unsigned got, longint unsigned want);
    if (got != want) begin
      report_mismatch($sformatf("readout %0d %s got %0d want %0d",
                                readouts_seen, name, got, want));
    end
  endtask

  // advance the model by one accepted request and queue its readout
  function automatic void predict_readout(echo_req_t r);
    readout_t    o;
    int unsigned cm;
    o.trigger = 1'b0;
    o.done = 1'b0;
    if (r.mode == MODE_TICK) begin
      countdown_q = countdown_q - 16'd1;
      if (countdown_q == '0) begin
        countdown_q = upd_ticks_q;
        cm = width_q / US_PER_CM;
        for (int k = 0; k < NumDigits; k++) begin
          digits_q[k] = DigitW'(cm % RADIX);
          cm = cm / RADIX;
        end
        width_q = '0;
        o.trigger = 1'b1;
        o.done = 1'b1;
      end
      backplane_q = ~backplane_q;
    end else if (r.level == LEVEL_FALL) begin
      // a zero rate makes the divider saturate
      if (rate_q == '0) width_q = '1;
      else width_q = r.count / {{(CountW-RateW){1'b0}}, rate_q};
    end
    o.backplane = backplane_q;
    o.digits = digits_q;
    o.width = width_q;
    readout_q.push_back(o);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_readout(pend);
        requests_sent++;
        if (idle_bursts_on && $urandom_range(0, 5) == 0) offer_gap = $urandom_range(1, 19);
      end
      if (!in_valid_i || in_ready_o) begin
        if (offer_gap > 0 || request_q.size() == 0) begin
          if (offer_gap > 0) offer_gap--;
          in_valid_i <= 1'b0;
        end else begin
          pend = request_q.pop_front();
          in_valid_i <= 1'b1;
          mode_i <= pend.mode;
          echo_level_i <= pend.level;
          capture_count_i <= pend.count;
        end
      end
    end
  end

  // result ready: random stall bursts plus the long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        accept_hold = LONG_HOLD;
      end
      if (accept_hold > 0) begin
        accept_hold--;
        out_ready_i <= 1'b0;
      end else if (idle_bursts_on && $urandom_range(0, 7) == 0) begin
        accept_hold = $urandom_range(1, 19);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  // readout monitor
  always @(posedge clk_i) begin : monitor
    readout_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      readouts_seen++;
      if (update_done_o) refreshes_seen++;
      if (readout_q.size() == 0) begin
        report_mismatch($sformatf("readout %0d arrived with nothing pending", readouts_seen));
      end else begin
        want = readout_q.pop_front();
        check_field("backplane", backplane_o, want.backplane);
        check_field("trigger_start", trigger_start_o, want.trigger);
        check_field("update_done", update_done_o, want.done);
        check_field("digit_ones", digit_ones_o, want.digits[0]);
        check_field("digit_tens", digit_tens_o, want.digits[1]);
        check_field("digit_hundreds", digit_hundreds_o, want.digits[2]);
        check_field("digit_thousands", digit_thousands_o, want.digits[3]);
        check_field("echo_width_us", echo_width_us_o, want.width);
      end
    end
  end

  task automatic push_req(logic mode, logic level, logic [CountW-1:0] count);
    echo_req_t r;
    r.mode = mode;
    r.level = level;
    r.count = count;
    request_q.push_back(r);
  endtask

  task automatic push_ticks(int unsigned n);
    repeat (n) push_req(MODE_TICK, 1'($urandom()), $urandom());
  endtask

  // capture counts: full range, the near-display range, extremes, varied sizes
  function automatic logic [CountW-1:0] rand_count();
    logic [CountW-1:0] c;
    case ($urandom_range(0, 7))
      0, 1:    c = $urandom();
      2, 3:    c = $urandom_range(0, 14_500_000);
      4:       c = $urandom_range(0, 1) ? '1 : '0;
      default: c = $urandom() >> $urandom_range(0, 31);
    endcase
    return c;
  endfunction

  // setup then access phase; upper pwdata bits beyond the register are noise
  task automatic write_reg(urm_reg_e idx, logic [31:0] value);
    logic [31:0] noise;
    logic [31:0] data;
    noise = $urandom();
    if (idx == REG_UPDATE_TICKS) begin
      data = {noise[31:TicksW], value[TicksW-1:0]};
    end else begin
      data = {noise[31:RateW], value[RateW-1:0]};
    end
    @(posedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= AddrW'(4 * int'(idx));
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_UPDATE_TICKS) upd_ticks_q = value[TicksW-1:0];
    else rate_q = value[RateW-1:0];
  endtask

  // wait until every request went in and every readout came back
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (request_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (readout_q.size() != 0 && waited < 4000) begin
      @(posedge clk_i);
      waited++;
    end
    if (readout_q.size() != 0) begin
      report_mismatch($sformatf("%0d readouts never arrived", readout_q.size()));
      readout_q.delete();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // tick up to the next reload, with a falling edge just before it
  task automatic reach_update(logic [CountW-1:0] count);
    int unsigned ticks_left;
    ticks_left = (countdown_q == '0) ? (1 << TicksW) : countdown_q;
    push_ticks(ticks_left - 1);
    push_req(MODE_EDGE, LEVEL_FALL, count);
    push_req(MODE_TICK, LEVEL_RISE, '0);
  endtask

  // mostly rise/fall pairs followed by ticks, some stray requests
  task automatic push_random_mix(int unsigned n);
    int unsigned pushed;
    int unsigned pick;
    int unsigned trail;
    pushed = 0;
    while (pushed < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        push_req(MODE_EDGE, LEVEL_RISE, $urandom());
        push_req(MODE_EDGE, LEVEL_FALL, rand_count());
        trail = $urandom_range(0, 3);
        push_ticks(trail);
        pushed += 2 + trail;
      end else if (pick < 8) begin
        push_ticks(1);
        pushed++;
      end else begin
        push_req(1'($urandom()), 1'($urandom()), rand_count());
        pushed++;
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (3) @(posedge clk_i);

    // each request kind at reset settings; rising edges carry junk counts
    push_req(MODE_EDGE, LEVEL_RISE, '1);
    push_req(MODE_EDGE, LEVEL_FALL, '0);
    push_req(MODE_TICK, LEVEL_RISE, '1);
    push_req(MODE_EDGE, LEVEL_FALL, '1);
    push_req(MODE_EDGE, LEVEL_RISE, 32'h5a5a_a5a5);
    push_req(MODE_TICK, LEVEL_FALL, '0);
    settle();

    // new period only applies at the next reload; 10000 cm wraps to zero
    write_reg(REG_UPDATE_TICKS, 32'd1);
    reach_update(32'd14_500_000);
    settle();

    // one tick per refresh from here: all nines, missed echo, full count
    write_reg(REG_TICKS_PER_US, 32'd1);
    push_req(MODE_EDGE, LEVEL_FALL, 32'd579_999);
    push_ticks(2);
    push_req(MODE_EDGE, LEVEL_FALL, '1);
    push_ticks(1);
    settle();

    // zero rate saturates the width
    write_reg(REG_TICKS_PER_US, 32'd0);
    push_req(MODE_EDGE, LEVEL_FALL, 32'd123);
    push_ticks(1);
    settle();

    // top rate; a later rising edge keeps the stored width
    write_reg(REG_TICKS_PER_US, 32'd255);
    push_req(MODE_EDGE, LEVEL_FALL, '1);
    push_req(MODE_EDGE, LEVEL_RISE, 32'd7);
    push_ticks(2);
    settle();

    // random rounds, each with its own register settings
    for (int r = 0; r < RANDOM_ROUNDS; r++) begin
      write_reg(REG_UPDATE_TICKS, (r % 2) ? $urandom_range(1, 4) : $urandom_range(5, 16));
      case (r)
        0:       write_reg(REG_TICKS_PER_US, 32'd0);
        1:       write_reg(REG_TICKS_PER_US, 32'd255);
        2:       write_reg(REG_TICKS_PER_US, 32'd1);
        default: write_reg(REG_TICKS_PER_US, $urandom_range(1, 255));
      endcase
      idle_bursts_on = (r != 2);
      push_random_mix(ROUND_ITEMS);
      // block the result side so the meter backs up into its input
      if (r == 1) hold_asks++;
      settle();
    end

    // zero period: the reload value is zero and the next tick wraps the countdown
    idle_bursts_on = 1'b0;
    write_reg(REG_TICKS_PER_US, $urandom_range(1, 255));
    write_reg(REG_UPDATE_TICKS, 32'd0);
    reach_update(rand_count());
    push_ticks(3);
    settle();
    // longest period leaves the running countdown alone
    write_reg(REG_UPDATE_TICKS, 32'hffff);
    push_req(MODE_EDGE, LEVEL_FALL, rand_count());
    push_ticks(4);
    settle();
    repeat (200) @(posedge clk_i);

    $display("summary: %0d requests sent, %0d readouts checked, %0d digit refreshes",
             requests_sent, readouts_seen, refreshes_seen);
    $display("summary: update period 0 to 65535, rate 0 to 255, %0d mismatches", errors);
    if (errors == 0) begin
      $display("ultrasonic_range_meter_tb: done, clean");
    end else begin
      $display("ultrasonic_range_meter_tb: done, errors");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin : watchdog
    #(60_000_000);
    $display("ultrasonic_range_meter_tb: done, errors");
    $finish;
  end

endmodule
